// ----- design/raar_pkg.sv -----
// Shared types, constants and state codes of the area-average resampler.
`default_nettype none
package raar_pkg;

   localparam int unsigned SizeBits = 9;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       out_last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      REG_SOURCE_WIDTH  = 2'd0,
      REG_SOURCE_HEIGHT = 2'd1,
      REG_TARGET_WIDTH  = 2'd2,
      REG_TARGET_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WIN_DIV,
      ST_WIN_NEXT,
      ST_WIN_FIX,
      ST_COUNT,
      ST_SUM_ADDR,
      ST_SUM_ACC,
      ST_DIV,
      ST_DIV_NEXT,
      ST_RESULT
   } state_type;

endpackage
`default_nettype wire

// ----- design/rgb_area_average_resampler.sv -----
// Top level of the RGB area-average resampler: registers, sequencer and frame store.
`default_nettype none
// An emit request walks its source window one frame-store read per pixel,
// and uses one shared 32-bit serial divider for the four window bounds and
// the three channel means; an emit with a zero size goes straight to the
// response. The response appears with rsp_valid for one cycle and cannot
// be stalled; busy stays high until it has been shown.
module rgb_area_average_resampler
   import raar_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire req_payload_type      req_payload,
   output      logic                 rsp_valid,
   output      rsp_payload_type      rsp_payload,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [SizeBits-1:0]  csr_data
);

   localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AddrW  = $clog2(Depth);
   localparam int unsigned PtrW   = AddrW + 1;
   localparam int unsigned WB     = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HB     = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned DB     = 32;

   logic [SizeBits-1:0] sw_reg_ff, sh_reg_ff, tw_reg_ff, th_reg_ff;
   logic [WB-1:0] sw, tw;
   logic [HB-1:0] sh, th;

   assign sw = (32'(sw_reg_ff) > MAX_WIDTH)  ? WB'(MAX_WIDTH)  : WB'(sw_reg_ff);
   assign tw = (32'(tw_reg_ff) > MAX_WIDTH)  ? WB'(MAX_WIDTH)  : WB'(tw_reg_ff);
   assign sh = (32'(sh_reg_ff) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(sh_reg_ff);
   assign th = (32'(th_reg_ff) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(th_reg_ff);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_reg_ff <= '0;
         sh_reg_ff <= '0;
         tw_reg_ff <= '0;
         th_reg_ff <= '0;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_SOURCE_WIDTH:  sw_reg_ff <= csr_data;
            REG_SOURCE_HEIGHT: sh_reg_ff <= csr_data;
            REG_TARGET_WIDTH:  tw_reg_ff <= csr_data;
            REG_TARGET_HEIGHT: th_reg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [PtrW-1:0]  lp_ff, lp_in;
   logic [WB-1:0]    col_ff, col_in;
   logic [HB-1:0]    row_ff, row_in;
   logic [1:0]       step_ff, step_in;
   logic [WB-1:0]    x0_ff, x0_in, x1_ff, x1_in, sx_ff, sx_in;
   logic [HB-1:0]    y0_ff, y0_in, y1_ff, y1_in, sy_ff, sy_in;
   logic [DB-1:0]    cnt_ff, cnt_in;
   logic [DB-1:0]    sum_ff [3];
   logic [DB-1:0]    sum_in [3];
   logic [7:0]       avg_ff [3];
   logic [7:0]       avg_in [3];
   logic             last_ff, last_in;
   logic [AddrW-1:0] rd_addr_ff, rd_addr_in;

   logic             div_start;
   logic [DB-1:0]    div_a, div_b, div_q;
   logic             div_done;
   logic [23:0]      rd_data;
   logic             wr_en;
   logic [PtrW-1:0]  wrap, lp_cur, lp_nxt;
   logic [DB-1:0]    o_idx, s_sz, n_sz;
   logic [DB-1:0]    prod;

   assign wrap = (sw != '0 && sh != '0) ? PtrW'(sw) * PtrW'(sh) : PtrW'(Depth);
   assign lp_cur = (lp_ff >= wrap) ? '0 : lp_ff;
   assign lp_nxt = lp_cur + 1'b1;
   assign wr_en  = start && !busy && !req_payload.req_type;

   raar_ram #(.WIDTH(24), .DEPTH(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (lp_cur[AddrW-1:0]),
      .wr_data ({req_payload.in_blue, req_payload.in_green, req_payload.in_red}),
      .rd_addr (rd_addr_in),
      .rd_data (rd_data)
   );

   raar_divider #(.WIDTH(DB)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   // Window steps: 0 column start, 1 column end, 2 row start, 3 row end.
   always_comb begin
      o_idx = step_ff[1] ? DB'(row_ff) : DB'(col_ff);
      s_sz  = step_ff[1] ? DB'(sh) : DB'(sw);
      n_sz  = step_ff[1] ? DB'(th) : DB'(tw);
      prod  = step_ff[0] ? (o_idx + 1'b1) * s_sz + n_sz - 1'b1 : o_idx * s_sz;
   end

   always_comb begin
      state_in   = state_ff;
      lp_in      = lp_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      step_in    = step_ff;
      x0_in      = x0_ff;
      x1_in      = x1_ff;
      y0_in      = y0_ff;
      y1_in      = y1_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      avg_in     = avg_ff;
      last_in    = last_ff;
      rd_addr_in = rd_addr_ff;
      div_start  = 1'b0;
      div_a      = prod;
      div_b      = n_sz;
      busy       = (state_ff != ST_IDLE);
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!req_payload.req_type) begin
                  lp_in = (lp_nxt >= wrap) ? '0 : lp_nxt;
               end else if (tw == '0 || th == '0) begin
                  col_in   = '0;
                  row_in   = '0;
                  avg_in   = '{8'd0, 8'd0, 8'd0};
                  last_in  = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  if (col_ff >= tw) col_in = '0;
                  if (row_ff >= th) row_in = '0;
                  avg_in  = '{8'd0, 8'd0, 8'd0};
                  sum_in  = '{DB'(0), DB'(0), DB'(0)};
                  step_in = '0;
                  state_in = (sw == '0 || sh == '0) ? ST_RESULT : ST_WIN_DIV;
               end
            end
         end
         ST_WIN_DIV: begin
            div_start = 1'b1;
            state_in  = ST_WIN_NEXT;
         end
         ST_WIN_NEXT: begin
            if (div_done) begin
               unique case (step_ff)
                  2'd0: x0_in = WB'(div_q);
                  2'd1: x1_in = (div_q > DB'(sw)) ? sw : WB'(div_q);
                  2'd2: y0_in = HB'(div_q);
                  default: y1_in = (div_q > DB'(sh)) ? sh : HB'(div_q);
               endcase
               step_in  = step_ff + 1'b1;
               state_in = (step_ff == 2'd3) ? ST_WIN_FIX : ST_WIN_DIV;
            end
         end
         ST_WIN_FIX: begin
            // An empty span is widened to one pixel, still clipped to the source.
            if (x1_ff <= x0_ff) x1_in = (x0_ff + 1'b1 > sw) ? sw : x0_ff + 1'b1;
            if (y1_ff <= y0_ff) y1_in = (y0_ff + 1'b1 > sh) ? sh : y0_ff + 1'b1;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            cnt_in   = DB'(x1_ff - x0_ff) * DB'(y1_ff - y0_ff);
            sx_in    = x0_ff;
            sy_in    = y0_ff;
            state_in = (x1_ff > x0_ff && y1_ff > y0_ff) ? ST_SUM_ADDR : ST_DIV;
         end
         ST_SUM_ADDR: begin
            rd_addr_in = AddrW'(DB'(sy_ff) * DB'(sw) + DB'(sx_ff));
            state_in   = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            // The store registers the address set in the previous cycle.
            sum_in[0] = sum_ff[0] + DB'(rd_data[7:0]);
            sum_in[1] = sum_ff[1] + DB'(rd_data[15:8]);
            sum_in[2] = sum_ff[2] + DB'(rd_data[23:16]);
            if (sx_ff + 1'b1 < x1_ff) begin
               sx_in    = sx_ff + 1'b1;
               state_in = ST_SUM_ADDR;
            end else if (sy_ff + 1'b1 < y1_ff) begin
               sx_in    = x0_ff;
               sy_in    = sy_ff + 1'b1;
               state_in = ST_SUM_ADDR;
            end else begin
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               div_start = 1'b1;
               div_a     = sum_ff[step_ff];
               div_b     = cnt_ff;
               state_in  = ST_DIV_NEXT;
            end
         end
         ST_DIV_NEXT: begin
            if (div_done) begin
               avg_in[step_ff] = div_q[7:0];
               step_in  = step_ff + 1'b1;
               state_in = (step_ff == 2'd2) ? ST_RESULT : ST_DIV;
            end
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
            if (tw != '0 && th != '0) begin
               last_in = 1'b0;
               if (col_ff + 1'b1 >= tw) begin
                  col_in = '0;
                  if (row_ff + 1'b1 >= th) begin
                     row_in  = '0;
                     last_in = 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The last flag for the shown response is worked out in the same cycle.
   always_comb begin
      rsp_payload.out_red   = avg_ff[0];
      rsp_payload.out_green = avg_ff[1];
      rsp_payload.out_blue  = avg_ff[2];
      rsp_payload.out_last  = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lp_ff    <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         step_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         lp_ff    <= lp_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         step_ff  <= step_in;
         last_ff  <= last_in;
      end
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      y0_ff      <= y0_in;
      y1_ff      <= y1_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      cnt_ff     <= cnt_in;
      sum_ff     <= sum_in;
      avg_ff     <= avg_in;
      rd_addr_ff <= rd_addr_in;
   end

endmodule
`default_nettype wire

// ----- design/raar_ram.sv -----
// Generic single-port write, single-port registered read memory.
`default_nettype none
module raar_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- design/raar_divider.sv -----
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module raar_divider #(
   parameter int unsigned WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output      logic             done,
   output      logic [WIDTH-1:0] quotient
);

   localparam int unsigned CntBits = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]   quo_ff, quo_in;
   logic [WIDTH-1:0]   rem_ff, rem_in;
   logic [WIDTH-1:0]   dsr_ff, dsr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [WIDTH:0]     trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WIDTH-1]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CntBits'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift one dividend bit into the remainder and try a subtraction.
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- tb/rgb_area_average_resampler_test.sv -----
// Self-checking testbench of the RGB area-average resampler with a built-in pixel predictor.
`default_nettype none
module rgb_area_average_resampler_test;
   import raar_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned StoreDepth = 65536;
   localparam int unsigned SizeLimit  = 256;
   localparam int unsigned TargetItems = 1950;
   localparam int unsigned QuietItems  = 1750;
   localparam int unsigned StallLimit  = 20000;
   localparam int unsigned DrainCycles = 50;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_payload_type     req_payload = '0;
   logic                rsp_valid;
   rsp_payload_type     rsp_payload;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = '0;
   logic [SizeBits-1:0] csr_data = '0;

   rgb_area_average_resampler u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Predictor state.
   logic [23:0]     pix_store [StoreDepth];
   int unsigned     load_ptr;
   int unsigned     col_count;
   int unsigned     row_count;
   logic [8:0]      size_reg [4];

   rsp_payload_type pixel_queue [$];
   int unsigned     error_count;
   int unsigned     item_count;
   int unsigned     stall_count;

   function automatic int unsigned clamp(logic [8:0] v);
      return (v > SizeLimit) ? SizeLimit : int'(v);
   endfunction

   function automatic void span(int unsigned o, int unsigned s, int unsigned n,
                                output int unsigned lo, output int unsigned hi);
      lo = (o * s) / n;
      hi = ((o + 1) * s + n - 1) / n;
      if (hi > s) hi = s;
      if (hi <= lo) hi = lo + 1;
      if (hi > s) hi = s;
   endfunction

   // Advances the predictor by one request; returns 1 when a pixel is produced.
   function automatic bit predict_pixel(req_payload_type p, output rsp_payload_type px);
      int unsigned sw, sh, tw, th, wrap, x0, x1, y0, y1, cnt;
      int unsigned sum_r, sum_g, sum_b;
      logic [23:0] v;
      sw = clamp(size_reg[REG_SOURCE_WIDTH]);
      sh = clamp(size_reg[REG_SOURCE_HEIGHT]);
      tw = clamp(size_reg[REG_TARGET_WIDTH]);
      th = clamp(size_reg[REG_TARGET_HEIGHT]);
      px = '0;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      if (!p.req_type) begin
         wrap = (sw != 0 && sh != 0) ? sw * sh : StoreDepth;
         if (load_ptr >= wrap) load_ptr = 0;
         pix_store[load_ptr % StoreDepth] = {p.in_blue, p.in_green, p.in_red};
         load_ptr++;
         if (load_ptr >= wrap) load_ptr = 0;
         return 1'b0;
      end
      if (tw == 0 || th == 0) begin
         col_count = 0;
         row_count = 0;
         px.out_last = 1'b1;
         return 1'b1;
      end
      if (col_count >= tw) col_count = 0;
      if (row_count >= th) row_count = 0;
      if (sw != 0 && sh != 0) begin
         span(col_count, sw, tw, x0, x1);
         span(row_count, sh, th, y0, y1);
         cnt = (x1 - x0) * (y1 - y0);
         for (int unsigned sy = y0; sy < y1; sy++) begin
            for (int unsigned sx = x0; sx < x1; sx++) begin
               v = pix_store[(sy * sw + sx) % StoreDepth];
               sum_r += v[7:0];
               sum_g += v[15:8];
               sum_b += v[23:16];
            end
         end
         if (cnt != 0) begin
            sum_r /= cnt;
            sum_g /= cnt;
            sum_b /= cnt;
         end
      end
      col_count++;
      if (col_count >= tw) begin
         col_count = 0;
         row_count++;
         if (row_count >= th) begin
            row_count = 0;
            px.out_last = 1'b1;
         end
      end
      px.out_red   = sum_r[7:0];
      px.out_green = sum_g[7:0];
      px.out_blue  = sum_b[7:0];
      return 1'b1;
   endfunction

   // Result checker: results are read before the edge updates them.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pixel_queue.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %h", $time, rsp_payload);
            error_count++;
         end else begin
            rsp_payload_type e;
            e = pixel_queue.pop_front();
            if (e.out_red !== rsp_payload.out_red) begin
               $display("%0t: out_red expected %h actual %h", $time, e.out_red,
                        rsp_payload.out_red);
               error_count++;
            end
            if (e.out_green !== rsp_payload.out_green) begin
               $display("%0t: out_green expected %h actual %h", $time, e.out_green,
                        rsp_payload.out_green);
               error_count++;
            end
            if (e.out_blue !== rsp_payload.out_blue) begin
               $display("%0t: out_blue expected %h actual %h", $time, e.out_blue,
                        rsp_payload.out_blue);
               error_count++;
            end
            if (e.out_last !== rsp_payload.out_last) begin
               $display("%0t: out_last expected %b actual %b", $time, e.out_last,
                        rsp_payload.out_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= StallLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Issues one request; a typed expectation replaces the predicted one when given.
   task automatic send_request(req_payload_type p, bit typed, rsp_payload_type typed_px);
      rsp_payload_type px;
      int unsigned gap;
      start       <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (busy);
      if (predict_pixel(p, px)) pixel_queue.push_back(typed ? typed_px : px);
      item_count++;
      if (item_count < QuietItems && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pixel_queue.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(reg_index_type idx, logic [8:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg[idx] = value;
   endtask

   function automatic req_payload_type random_load();
      req_payload_type p;
      p = {1'b0, 8'($urandom), 8'($urandom), 8'($urandom)};
      return p;
   endfunction

   typedef struct {
      bit              is_cfg;
      reg_index_type   idx;
      logic [8:0]      value;
      req_payload_type req;
      bit              typed;
      rsp_payload_type px;
   } step_row_type;

   localparam req_payload_type Emit  = '{req_type: 1'b1, default: '0};
   localparam req_payload_type White = '{1'b0, 8'hff, 8'hff, 8'hff};
   localparam req_payload_type Black = '{1'b0, 8'h00, 8'h00, 8'h00};
   localparam rsp_payload_type ZeroLast  = '{8'h00, 8'h00, 8'h00, 1'b1};
   localparam rsp_payload_type WhiteLast = '{8'hff, 8'hff, 8'hff, 1'b1};

   step_row_type directed [] = '{
      // With every size zero after reset, an emit gives a blank final pixel.
      '{0, REG_SOURCE_WIDTH, 0, Emit, 1, ZeroLast},
      '{1, REG_SOURCE_WIDTH, 9'd2, Black, 0, '0},
      '{1, REG_SOURCE_HEIGHT, 9'd2, Black, 0, '0},
      '{1, REG_TARGET_WIDTH, 9'd1, Black, 0, '0},
      '{1, REG_TARGET_HEIGHT, 9'd1, Black, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, White, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, White, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, White, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, White, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Emit, 1, WhiteLast},
      '{0, REG_SOURCE_WIDTH, 0, Black, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Black, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Black, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Emit, 0, '0},
      // An oversized target width saturates; each window is one pixel wide.
      '{1, REG_TARGET_WIDTH, 9'd511, Black, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Emit, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Emit, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Emit, 0, '0},
      // Shrinking the target leaves the column counter out of range.
      '{1, REG_TARGET_WIDTH, 9'd1, Black, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Emit, 0, '0},
      '{1, REG_SOURCE_WIDTH, 9'd0, Black, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Emit, 1, ZeroLast},
      '{1, REG_TARGET_HEIGHT, 9'd0, Black, 0, '0},
      '{0, REG_SOURCE_WIDTH, 0, Emit, 1, ZeroLast}
   };

   initial begin
      logic [8:0] sz [4];
      int unsigned loads, emits;
      load_ptr    = 0;
      col_count   = 0;
      row_count   = 0;
      item_count  = 0;
      foreach (size_reg[i]) size_reg[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_cfg) write_size(directed[i].idx, directed[i].value);
         else send_request(directed[i].req, directed[i].typed, directed[i].px);
      end

      while (item_count < TargetItems) begin
         case ($urandom_range(0, 9))
            0: sz = '{($urandom_range(0, 1) != 0) ? 9'd256 : 9'($urandom_range(257, 511)),
                      9'd1, 9'($urandom_range(1, 3)), 9'($urandom_range(1, 2))};
            1: sz = '{9'd1, ($urandom_range(0, 1) != 0) ? 9'd511 : 9'd256,
                      9'($urandom_range(1, 2)), 9'($urandom_range(1, 3))};
            2: begin
               sz = '{9'($urandom_range(1, 6)), 9'($urandom_range(1, 6)),
                      9'($urandom_range(1, 6)), 9'($urandom_range(1, 6))};
               sz[$urandom_range(0, 3)] = '0;
            end
            3: sz = '{9'($urandom_range(1, 8)), 9'($urandom_range(1, 4)),
                      ($urandom_range(0, 1) != 0) ? 9'd511 : 9'd256, 9'd1};
            default: sz = '{9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
                            9'($urandom_range(1, 16)), 9'($urandom_range(1, 16))};
         endcase
         for (int r = 0; r < 4; r++) write_size(reg_index_type'(r), sz[r]);
         // A full frame load makes every entry a window can read valid.
         loads = clamp(sz[0]) * clamp(sz[1]);
         if (loads == 0) loads = $urandom_range(0, 5);
         repeat (loads) send_request(random_load(), 1'b0, '0);
         emits = clamp(sz[2]) * clamp(sz[3]) + $urandom_range(0, 3);
         if (emits > 60) emits = $urandom_range(20, 60);
         for (int unsigned k = 0; k < emits; k++) begin
            if ($urandom_range(0, 9) == 0) send_request(random_load(), 1'b0, '0);
            else send_request(Emit | 25'($urandom_range(0, 1) << 3), 1'b0, '0);
            if ($urandom_range(0, 99) == 0) settle();
         end
      end

      settle();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
design/raar_pkg.sv
design/raar_ram.sv
design/raar_divider.sv
design/rgb_area_average_resampler.sv
tb/rgb_area_average_resampler_test.sv
